>>> rtl/core/plet_pkg.sv
// types, constants and the per-pass parse function of the log tokenizer
`default_nettype none

package plet_pkg;

  localparam int unsigned GROUP_DIGITS   = 2;
  localparam int unsigned FINAL_DIGITS   = 13;
  localparam int unsigned TOK_FIFO_DEPTH = 4;
  localparam int unsigned TOK_PTR_W      = $clog2(TOK_FIFO_DEPTH);
  localparam int unsigned TOK_CNT_W      = $clog2(TOK_FIFO_DEPTH + 1);
  localparam int unsigned MAX_PASSES     = 4;

  localparam logic [7:0] BYTE_LF    = 8'h0a;
  localparam logic [7:0] BYTE_CR    = 8'h0d;
  localparam logic [7:0] BYTE_SPACE = 8'h20;
  localparam logic [7:0] BYTE_ZERO  = 8'h30;
  localparam logic [7:0] BYTE_NINE  = 8'h39;
  localparam logic [7:0] BYTE_SEMI  = 8'h3b;

  localparam logic [3:0] GROUP_LEN = 4'(GROUP_DIGITS);
  localparam logic [3:0] FINAL_LEN = 4'(FINAL_DIGITS);

  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ESC_A    = 3'd0,
    CFG_ESC_B    = 3'd1,
    CFG_WR_CODE  = 3'd2,
    CFG_RD_CODE  = 3'd3,
    CFG_NONE_CODE = 3'd4
  } cfg_reg_t;

  typedef enum logic [2:0] {
    TK_NL   = 3'd0,
    TK_HEX  = 3'd1,
    TK_CHAR = 3'd2,
    TK_WR   = 3'd3,
    TK_RD   = 3'd4,
    TK_NONE = 3'd5,
    TK_ECHO = 3'd6,
    TK_END  = 3'd7
  } tok_kind_t;

  typedef enum logic [2:0] {
    ST_TEXT  = 3'd0,
    ST_ESC   = 3'd1,
    ST_CODE  = 3'd2,
    ST_SEP1  = 3'd3,
    ST_GRP1  = 3'd4,
    ST_SEP2  = 3'd5,
    ST_GRP2  = 3'd6,
    ST_FINAL = 3'd7
  } parse_state_t;

  typedef struct packed {
    logic [7:0] esc_a;
    logic [7:0] esc_b;
    logic [7:0] wr_code;
    logic [7:0] rd_code;
    logic [7:0] none_code;
  } cfg_t;

  typedef struct packed {
    parse_state_t ps;
    logic [3:0]   countdown;
    logic [7:0]   pending;
    logic         line_start;
  } pstate_t;

  typedef struct packed {
    tok_kind_t  kind;
    logic [7:0] value;
    logic       last;
  } tok_t;

  typedef struct packed {
    pstate_t    st;
    logic       again;
    logic [1:0] n;
    tok_t       t0;
    tok_t       t1;
  } pass_t;

  localparam pstate_t PSTATE_RESET = '{ps: ST_TEXT, countdown: 4'd0, pending: 8'd0,
                                       line_start: 1'b1};

  function automatic logic is_dec_char(logic [7:0] b);
    return (b >= BYTE_ZERO) && (b <= BYTE_NINE);
  endfunction

  function automatic tok_t mk_tok(tok_kind_t k, logic [7:0] v);
    tok_t t;
    t.kind  = k;
    t.value = v;
    t.last  = 1'b0;
    return t;
  endfunction

  // one pass of the parser over a byte; again asks for another pass on the same byte
  function automatic pass_t plet_handle(pstate_t s, logic [7:0] b, cfg_t c);
    pass_t     p;
    logic      bad;
    tok_kind_t lbl;
    p.st    = s;
    p.again = 1'b0;
    p.n     = 2'd0;
    p.t0    = mk_tok(TK_NL, 8'd0);
    p.t1    = mk_tok(TK_NL, 8'd0);
    bad     = 1'b0;
    lbl     = TK_NONE;
    case (s.ps)
      ST_TEXT: begin
        if (b == BYTE_LF) begin
          p.n = 2'd1;
          p.st.line_start = 1'b1;
        end else if (b == BYTE_CR) begin
          p.st.line_start = 1'b0;
        end else if (b == c.esc_a || b == c.esc_b) begin
          p.st.pending = b;
          p.st.ps = ST_ESC;
        end else begin
          p.n  = 2'd1;
          p.t0 = mk_tok((b < BYTE_SPACE) ? TK_HEX : TK_CHAR, b);
          p.st.line_start = 1'b0;
        end
      end
      ST_ESC: begin
        if (b == c.wr_code || b == c.rd_code || b == c.none_code) begin
          lbl = (b == c.wr_code) ? TK_WR : (b == c.rd_code) ? TK_RD : TK_NONE;
          if (!s.line_start) begin
            p.n  = 2'd2;
            p.t1 = mk_tok(lbl, 8'd0);
          end else begin
            p.n  = 2'd1;
            p.t0 = mk_tok(lbl, 8'd0);
          end
          p.st.ps = (lbl == TK_NONE) ? ST_TEXT : ST_CODE;
          p.st.line_start = (lbl == TK_NONE);
        end else begin
          p.n  = 2'd1;
          p.t0 = mk_tok(TK_HEX, s.pending);
          p.st.ps = ST_TEXT;
          p.st.line_start = 1'b0;
          p.again = 1'b1;
        end
      end
      ST_CODE, ST_SEP1: begin
        if (b == BYTE_SEMI) begin
          p.n  = 2'd1;
          p.t0 = mk_tok(TK_ECHO, b);
          p.st.ps = (s.ps == ST_CODE) ? ST_SEP1 : ST_SEP2;
        end else if (is_dec_char(b)) begin
          p.n  = 2'd1;
          p.t0 = mk_tok(TK_ECHO, b);
          p.st.countdown = GROUP_LEN;
          p.st.ps = (s.ps == ST_CODE) ? ST_GRP1 : ST_GRP2;
        end else begin
          bad = 1'b1;
        end
      end
      ST_SEP2: begin
        if (is_dec_char(b)) begin
          p.n  = 2'd1;
          p.t0 = mk_tok(TK_ECHO, b);
          p.st.countdown = FINAL_LEN;
          p.st.ps = ST_FINAL;
        end else begin
          bad = 1'b1;
        end
      end
      default: begin
        if (s.countdown > 4'd1) begin
          p.st.countdown = s.countdown - 4'd1;
          if (is_dec_char(b)) begin
            p.n  = 2'd1;
            p.t0 = mk_tok(TK_ECHO, b);
          end else begin
            bad = 1'b1;
          end
        end else begin
          // group complete: close it and look at the byte again
          p.st.countdown = 4'd0;
          if (s.ps == ST_FINAL) begin
            p.n = 2'd1;
            p.st.ps = ST_TEXT;
          end else begin
            p.st.ps = (s.ps == ST_GRP1) ? ST_SEP1 : ST_SEP2;
          end
          p.again = 1'b1;
        end
      end
    endcase
    if (bad) begin
      p.n  = 2'd1;
      p.t0 = mk_tok(TK_NL, 8'd0);
      p.st.line_start = 1'b0;
      p.st.ps = ST_TEXT;
      p.again = 1'b1;
    end
    return p;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/plet_if.sv
// channel interfaces of the log tokenizer: input bytes, tokens, register writes
`default_nettype none

interface plet_in_if import plet_pkg::*; ();
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] data_byte;
  modport source (output valid, output func, output data_byte, input ready);
  modport sink   (input valid, input func, input data_byte, output ready);
endinterface

interface plet_tok_if import plet_pkg::*; ();
  logic       valid;
  logic       ready;
  tok_kind_t  token_kind;
  logic [7:0] token_value;
  logic       last_token;
  modport source (output valid, output token_kind, output token_value,
                  output last_token, input ready);
  modport sink   (input valid, input token_kind, input token_value,
                  input last_token, output ready);
endinterface

interface plet_cfg_if import plet_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [7:0]           data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/core/printer_log_escape_tokenizer.sv
// Printer log tokenizer: turns record bytes into newline, hex, char, label and
// barcode echo tokens, up to two per byte, and a record end token on func = 1.
// An item is registered on entry and parsed combinationally from that register in
// a single pass of logic (re-handling of a byte after a closed group or bad byte is
// unrolled there); its tokens go into a four-entry queue. The token port moves one
// token per cycle while tok.ready is high; a new item is taken once the queue has
// room for two tokens, even while earlier tokens still wait. Registers are written
// through the cfg channel, which is always ready; unknown indexes are ignored.
`default_nettype none

module printer_log_escape_tokenizer import plet_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  plet_in_if.sink   src,
  plet_tok_if.source tok,
  plet_cfg_if.sink  cfg
);

  cfg_t       regs;
  pstate_t    pst;
  pstate_t    pst_next;
  logic       hold_valid;
  logic       hold_func;
  logic [7:0] hold_byte;
  logic       consume;
  logic       room2;
  logic [1:0] cnt;
  tok_t       t0;
  tok_t       t1;
  pass_t      p;
  pstate_t    cur;
  logic       go;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.esc_a     <= 8'h10;
      regs.esc_b     <= 8'h00;
      regs.wr_code   <= 8'h00;
      regs.rd_code   <= 8'h00;
      regs.none_code <= 8'h00;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_ESC_A:     regs.esc_a     <= cfg.data;
        CFG_ESC_B:     regs.esc_b     <= cfg.data;
        CFG_WR_CODE:   regs.wr_code   <= cfg.data;
        CFG_RD_CODE:   regs.rd_code   <= cfg.data;
        CFG_NONE_CODE: regs.none_code <= cfg.data;
        default: ;
      endcase
    end
  end

  // input register; it drains only when the queue can take two tokens
  assign consume   = hold_valid && room2;
  assign src.ready = !hold_valid || room2;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (src.ready) begin
      hold_valid <= src.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (src.valid && src.ready) begin
      hold_func <= src.func;
      hold_byte <= src.data_byte;
    end
  end

  always_comb begin
    cnt      = 2'd0;
    t0       = mk_tok(TK_NL, 8'd0);
    t1       = mk_tok(TK_NL, 8'd0);
    cur      = pst;
    go       = 1'b1;
    p        = '0;
    if (hold_func) begin
      if (pst.ps == ST_FINAL) begin
        cnt = 2'd2;
        t1  = mk_tok(TK_END, 8'd0);
      end else begin
        cnt = 2'd1;
        t0  = mk_tok(TK_END, 8'd0);
      end
      cur = PSTATE_RESET;
    end else begin
      for (int i = 0; i < MAX_PASSES; i++) begin
        if (go) begin
          p = plet_handle(cur, hold_byte, regs);
          // tokens beyond the second are dropped
          if (p.n != 2'd0) begin
            if (cnt == 2'd0) begin
              t0 = p.t0;
            end else if (cnt == 2'd1) begin
              t1 = p.t0;
            end
            if (cnt != 2'd2) begin
              cnt = cnt + 2'd1;
            end
          end
          if (p.n == 2'd2) begin
            if (cnt == 2'd0) begin
              t0 = p.t1;
            end else if (cnt == 2'd1) begin
              t1 = p.t1;
            end
            if (cnt != 2'd2) begin
              cnt = cnt + 2'd1;
            end
          end
          cur = p.st;
          go  = p.again;
        end
      end
    end
    t0.last  = (cnt == 2'd1);
    t1.last  = (cnt == 2'd2);
    pst_next = cur;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pst <= PSTATE_RESET;
    end else if (consume) begin
      pst <= pst_next;
    end
  end

  plet_tok_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push_cnt (consume ? cnt : 2'd0),
    .push_t0  (t0),
    .push_t1  (t1),
    .room2    (room2),
    .tok      (tok)
  );

endmodule

`default_nettype wire

>>> rtl/core/plet_tok_fifo.sv
// token queue: takes up to two tokens a cycle, hands out one a cycle while the port is ready
`default_nettype none

module plet_tok_fifo import plet_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic [1:0] push_cnt,
  input  wire tok_t       push_t0,
  input  wire tok_t       push_t1,
  output logic            room2,
  plet_tok_if.source      tok
);

  tok_t                 mem [TOK_FIFO_DEPTH];
  logic [TOK_PTR_W-1:0] wr_ptr;
  logic [TOK_PTR_W-1:0] rd_ptr;
  logic [TOK_CNT_W-1:0] count;
  logic [TOK_PTR_W-1:0] wr_ptr1;
  logic                 pop;

  assign wr_ptr1 = wr_ptr + TOK_PTR_W'(1);
  assign pop     = tok.valid && tok.ready;
  assign room2   = count <= TOK_CNT_W'(TOK_FIFO_DEPTH - 2);

  assign tok.valid       = count != '0;
  assign tok.token_kind  = mem[rd_ptr].kind;
  assign tok.token_value = mem[rd_ptr].value;
  assign tok.last_token  = mem[rd_ptr].last;

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      mem[wr_ptr] <= push_t0;
    end
    if (push_cnt == 2'd2) begin
      mem[wr_ptr1] <= push_t1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + TOK_PTR_W'(push_cnt);
      if (pop) begin
        rd_ptr <= rd_ptr + TOK_PTR_W'(1);
      end
      count <= count + TOK_CNT_W'(push_cnt) - TOK_CNT_W'(pop);
    end
  end

endmodule

`default_nettype wire
